>>> hdl/aclfrt_pkg.sv
// ----------------------------------------------------------------------------
// ACL fragment reassembly tracker: shared definitions
// Table size, field widths, command and event codes, and the records that
// pass between the front end, the back end and the result channel.
// ----------------------------------------------------------------------------
package aclfrt_pkg;

  // Number of connection slots in the table (1 to 16).
  localparam int SLOTS  = 4;
  // Bits needed to index a slot.
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Depth of the queue between the front end and the back end.
  localparam int QDEPTH = 2;

  // Packet boundary code for a continuation fragment.
  localparam logic [1:0] PB_CONTINUATION = 2'd1;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result event codes.
  typedef enum logic [3:0] {
    EV_QUEUED    = 4'd0,
    EV_DELIVERED = 4'd1,
    EV_FLUSH     = 4'd2,
    EV_UNKNOWN   = 4'd3,
    EV_REFUSED   = 4'd4,
    EV_SKIPPED   = 4'd5,
    EV_OPENED    = 4'd6,
    EV_FULL      = 4'd7,
    EV_CLOSED    = 4'd8,
    EV_CLOSE_UNK = 4'd9
  } event_t;

  // A classified command, as held in the queue.
  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] handle;
    logic        is_start;
    logic [15:0] plen;
    logic [15:0] declared;
    logic        refused;
  } job_t;

  // One result item.
  typedef struct packed {
    event_t      ev;
    logic [3:0]  slot;
    logic [15:0] bytes;
    logic        last;
  } result_t;

endpackage

>>> hdl/aclfrt_if.sv
// ----------------------------------------------------------------------------
// ACL fragment reassembly tracker: channel interfaces
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------

// Command channel.
interface aclfrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] link_id;
  logic [1:0]  boundary_flag;
  logic [15:0] frag_len;
  logic [15:0] declared_size;
  logic        check_refused;

  modport source (
    output valid, command, link_id, boundary_flag, frag_len,
           declared_size, check_refused,
    input  ready
  );
  modport sink (
    input  valid, command, link_id, boundary_flag, frag_len,
           declared_size, check_refused,
    output ready
  );
endinterface

// Result channel.
interface aclfrt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [3:0]  slot_index;
  logic [15:0] message_bytes;
  logic        last_result;

  modport source (
    output valid, event_code, slot_index, message_bytes, last_result,
    input  ready
  );
  modport sink (
    input  valid, event_code, slot_index, message_bytes, last_result,
    output ready
  );
endinterface

>>> hdl/aclfrt_front.sv
// ----------------------------------------------------------------------------
// ACL fragment reassembly tracker: front end
// Accepts command items, classifies them and holds them in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module aclfrt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  aclfrt_in_if.sink            in_ch,
  output aclfrt_pkg::job_t     q_job,
  output logic                 q_valid,
  input  logic                 q_pop
);

  aclfrt_pkg::job_t queue_r [aclfrt_pkg::QDEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  aclfrt_pkg::job_t job_in;
  logic             push;

  // Classify the incoming item; the boundary code reduces to a start flag.
  always_comb begin
    job_in.cmd      = aclfrt_pkg::cmd_t'(in_ch.command);
    job_in.handle   = in_ch.link_id;
    job_in.is_start = (in_ch.boundary_flag != aclfrt_pkg::PB_CONTINUATION);
    job_in.plen     = in_ch.frag_len;
    job_in.declared = in_ch.declared_size;
    job_in.refused  = in_ch.check_refused;
  end

  // The unused command code is accepted and dropped here.
  assign in_ch.ready = (count_r != 2'(aclfrt_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready && (job_in.cmd != aclfrt_pkg::CMD_NONE);

  assign q_valid = (count_r != 2'd0);
  assign q_job   = queue_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

>>> hdl/aclfrt_back.sv
// ----------------------------------------------------------------------------
// ACL fragment reassembly tracker: back end
// Takes one queued command at a time, searches the slot table one slot per
// cycle, updates the matching slot and presents up to two results.
// ----------------------------------------------------------------------------
module aclfrt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aclfrt_pkg::job_t     q_job,
  input  logic                 q_valid,
  output logic                 q_pop,
  aclfrt_out_if.source         out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_OUT
  } state_t;

  localparam logic [aclfrt_pkg::SLOT_W-1:0] LAST_SLOT =
    aclfrt_pkg::SLOT_W'(aclfrt_pkg::SLOTS - 1);

  state_t                        state_r;
  aclfrt_pkg::job_t              cur_r;
  logic [aclfrt_pkg::SLOT_W-1:0] idx_r;

  // Slot table.
  logic        in_use_r [aclfrt_pkg::SLOTS];
  logic [11:0] handle_r [aclfrt_pkg::SLOTS];
  logic [15:0] exp_r    [aclfrt_pkg::SLOTS];
  logic [15:0] gat_r    [aclfrt_pkg::SLOTS];
  logic        pend_r   [aclfrt_pkg::SLOTS];
  logic        skip_r   [aclfrt_pkg::SLOTS];

  // Output stage.
  logic                  out_valid_r;
  aclfrt_pkg::result_t   out_res_r;
  aclfrt_pkg::result_t   res1_r;
  logic                  have1_r;

  // Search and update logic.
  logic                  hit;
  aclfrt_pkg::event_t    miss_ev;
  logic [3:0]            slot4;
  logic                  in_use_nxt;
  logic [15:0]           exp_nxt;
  logic [15:0]           gat_nxt;
  logic                  pend_nxt;
  logic                  skip_nxt;
  aclfrt_pkg::result_t   res_a;
  aclfrt_pkg::result_t   res_b;
  logic                  two;
  aclfrt_pkg::result_t   main_res;
  logic                  flush;
  logic                  proceed;
  logic [15:0]           g_base;
  logic [15:0]           e_eff;
  logic [15:0]           remain;
  logic [15:0]           total;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign slot4 = 4'(idx_r);

  // Match test for the slot under the search index.
  always_comb begin
    if (cur_r.cmd == aclfrt_pkg::CMD_OPEN) begin
      hit = !in_use_r[idx_r];
    end else begin
      hit = in_use_r[idx_r] && (handle_r[idx_r] == cur_r.handle);
    end
    case (cur_r.cmd)
      aclfrt_pkg::CMD_OPEN:  miss_ev = aclfrt_pkg::EV_FULL;
      aclfrt_pkg::CMD_CLOSE: miss_ev = aclfrt_pkg::EV_CLOSE_UNK;
      default:               miss_ev = aclfrt_pkg::EV_UNKNOWN;
    endcase
  end

  // Slot update and results for a command whose slot has been found.
  always_comb begin
    in_use_nxt = in_use_r[idx_r];
    exp_nxt    = exp_r[idx_r];
    gat_nxt    = gat_r[idx_r];
    pend_nxt   = pend_r[idx_r];
    skip_nxt   = skip_r[idx_r];
    flush      = 1'b0;
    proceed    = 1'b0;
    g_base     = gat_r[idx_r];
    e_eff      = exp_r[idx_r];
    remain     = 16'd0;
    total      = 16'd0;
    main_res   = '{ev: aclfrt_pkg::EV_QUEUED, slot: slot4, bytes: 16'd0, last: 1'b1};
    res_a      = main_res;
    res_b      = main_res;
    two        = 1'b0;
    case (cur_r.cmd)
      aclfrt_pkg::CMD_OPEN: begin
        in_use_nxt  = 1'b1;
        exp_nxt     = 16'd0;
        gat_nxt     = 16'd0;
        pend_nxt    = 1'b0;
        skip_nxt    = 1'b0;
        main_res.ev = aclfrt_pkg::EV_OPENED;
        res_a       = main_res;
      end
      aclfrt_pkg::CMD_CLOSE: begin
        in_use_nxt  = 1'b0;
        gat_nxt     = 16'd0;
        pend_nxt    = 1'b0;
        skip_nxt    = 1'b0;
        main_res.ev = aclfrt_pkg::EV_CLOSED;
        res_a       = main_res;
      end
      default: begin
        // A start packet first flushes a pending partial message.
        flush = cur_r.is_start && pend_r[idx_r];
        if (flush) begin
          g_base   = 16'd0;
          gat_nxt  = 16'd0;
          pend_nxt = 1'b0;
        end
        proceed = 1'b1;
        if (cur_r.is_start) begin
          if (cur_r.refused) begin
            skip_nxt    = 1'b1;
            main_res.ev = aclfrt_pkg::EV_REFUSED;
            proceed     = 1'b0;
          end else begin
            skip_nxt = 1'b0;
            exp_nxt  = cur_r.declared;
            e_eff    = cur_r.declared;
          end
        end else if (skip_r[idx_r]) begin
          main_res.ev = aclfrt_pkg::EV_SKIPPED;
          proceed     = 1'b0;
        end
        // Accumulate until the remainder is covered, then deliver.
        remain = e_eff - g_base;
        total  = g_base + cur_r.plen;
        if (proceed) begin
          if (cur_r.plen >= remain) begin
            main_res.ev    = aclfrt_pkg::EV_DELIVERED;
            main_res.bytes = total;
            gat_nxt        = 16'd0;
            pend_nxt       = 1'b0;
          end else begin
            main_res.ev = aclfrt_pkg::EV_QUEUED;
            gat_nxt     = total;
            pend_nxt    = 1'b1;
          end
        end
        if (flush) begin
          res_a = '{ev: aclfrt_pkg::EV_FLUSH, slot: slot4, bytes: gat_r[idx_r], last: 1'b0};
          res_b = main_res;
          two   = 1'b1;
        end else begin
          res_a = main_res;
        end
      end
    endcase
  end

  // Sequencer, slot table and output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      have1_r     <= 1'b0;
      idx_r       <= '0;
      for (int i = 0; i < aclfrt_pkg::SLOTS; i++) begin
        in_use_r[i] <= 1'b0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_job;
            idx_r   <= '0;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            state_r <= S_EXEC;
          end else if (idx_r == LAST_SLOT) begin
            out_res_r   <= '{ev: miss_ev, slot: 4'd0, bytes: 16'd0, last: 1'b1};
            have1_r     <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            idx_r <= idx_r + aclfrt_pkg::SLOT_W'(1);
          end
        end
        S_EXEC: begin
          in_use_r[idx_r] <= in_use_nxt;
          if (cur_r.cmd == aclfrt_pkg::CMD_OPEN) begin
            handle_r[idx_r] <= cur_r.handle;
          end
          exp_r[idx_r]  <= exp_nxt;
          gat_r[idx_r]  <= gat_nxt;
          pend_r[idx_r] <= pend_nxt;
          skip_r[idx_r] <= skip_nxt;
          out_res_r     <= res_a;
          res1_r        <= res_b;
          have1_r       <= two;
          out_valid_r   <= 1'b1;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (have1_r) begin
              out_res_r <= res1_r;
              have1_r   <= 1'b0;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_code    = out_res_r.ev;
  assign out_ch.slot_index    = out_res_r.slot;
  assign out_ch.message_bytes = out_res_r.bytes;
  assign out_ch.last_result   = out_res_r.last;

  // A non-final result is always followed at once by the final one.
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.ready && !out_res_r.last) |=> (out_valid_r && out_res_r.last))
    else $error("final result did not follow a non-final one");

  // An early flush is never the last result of its command.
  a_flush_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.ev == aclfrt_pkg::EV_FLUSH)) |-> !out_res_r.last)
    else $error("early flush marked as final result");

  // The queue is drained only while no result is outstanding.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid_r && q_valid))
    else $error("queue popped while a result is outstanding");

  // A reported open names a slot that is now in use.
  a_open_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.ev == aclfrt_pkg::EV_OPENED))
      |-> in_use_r[out_res_r.slot[aclfrt_pkg::SLOT_W-1:0]])
    else $error("opened slot not marked in use");

endmodule

>>> hdl/acl_fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// ACL fragment reassembly tracker
// Usage: commands (data packet header, open, close) enter on in_ch and results
// leave on out_ch, both valid/ready channels with a transfer when valid and
// ready are both high. Each command gives one or two results, the last of
// them flagged by last_result; the unused command code gives no result.
// A front end classifies commands into a two-entry queue, so in_ch keeps
// accepting while results wait. The back end takes one command from the
// queue, searches the table one slot per cycle (lowest first), updates the
// matching slot, then presents the result; on a miss there is no update.
// A second result is presented in the cycle after the first is taken.
// The back end takes its next command only once the last result of the
// current one has been taken. Reset (synchronous, rst_n low) empties the
// queue, drops any pending result and marks every slot free. While the
// receiver holds out_ch.ready low the result is held and the back end
// waits; the queue fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
module acl_fragment_reassembly_tracker (
  input  logic          clk,
  input  logic          rst_n,
  aclfrt_in_if.sink     in_ch,
  aclfrt_out_if.source  out_ch
);

  aclfrt_pkg::job_t q_job;
  logic             q_valid;
  logic             q_pop;

  // Command acceptance and classification.
  aclfrt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_job   (q_job),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // Slot search, table update and result delivery.
  aclfrt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (q_job),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/sv/acl_reassembly_checker.sv
// ----------------------------------------------------------------------------
// ACL reassembly tracker: result checker
// Watches the command and result channels of the tracker and keeps its own
// copy of the connection table. Each command transfer adds the results that
// the command must give to a queue of awaited results. Each result transfer
// is compared, field by field, with the oldest entry of that queue.
// ----------------------------------------------------------------------------
module acl_reassembly_checker (
  input  logic  clk,
  input  logic  rst_n,
  aclfrt_in_if  cmd_ch,
  aclfrt_out_if res_ch,
  output int    mismatch_count,
  output int    awaited_count,
  output int    checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted connection table.
  logic        slot_busy   [aclfrt_pkg::SLOTS];
  logic [11:0] slot_conn   [aclfrt_pkg::SLOTS];
  logic [15:0] want_bytes  [aclfrt_pkg::SLOTS];
  logic [15:0] have_bytes  [aclfrt_pkg::SLOTS];
  logic        part_held   [aclfrt_pkg::SLOTS];
  logic        refuse_rest [aclfrt_pkg::SLOTS];

  // Results still to arrive, oldest first, and those of the command in hand.
  aclfrt_pkg::result_t awaited_results [$];
  aclfrt_pkg::result_t step_results    [$];

  int event_tally [10];
  int fail_tally;
  int checked_tally;

  // Lowest busy slot that holds the given handle, or -1.
  function automatic int find_conn(logic [11:0] handle);
    for (int i = 0; i < aclfrt_pkg::SLOTS; i++) begin
      if (slot_busy[i] && slot_conn[i] == handle) return i;
    end
    return -1;
  endfunction

  function automatic void note_result(aclfrt_pkg::event_t ev, int slot, logic [15:0] bytes);
    aclfrt_pkg::result_t r;
    r.ev    = ev;
    r.slot  = 4'(slot);
    r.bytes = bytes;
    r.last  = 1'b0;
    step_results.push_back(r);
  endfunction

  // Applies one command to the table and queues the results it gives.
  function automatic void predict_command(aclfrt_pkg::cmd_t cmd, logic [11:0] handle,
                                          logic [1:0] boundary, logic [15:0] plen,
                                          logic [15:0] declared, logic refused);
    int          s;
    logic        go_on;
    logic [15:0] remain;
    logic [15:0] total;
    step_results.delete();
    s = -1;
    case (cmd)
      aclfrt_pkg::CMD_OPEN: begin
        for (int i = aclfrt_pkg::SLOTS - 1; i >= 0; i--) begin
          if (!slot_busy[i]) s = i;
        end
        if (s >= 0) begin
          slot_busy[s]   = 1'b1;
          slot_conn[s]   = handle;
          want_bytes[s]  = '0;
          have_bytes[s]  = '0;
          part_held[s]   = 1'b0;
          refuse_rest[s] = 1'b0;
          note_result(aclfrt_pkg::EV_OPENED, s, '0);
        end else begin
          note_result(aclfrt_pkg::EV_FULL, 0, '0);
        end
      end
      aclfrt_pkg::CMD_CLOSE: begin
        s = find_conn(handle);
        if (s >= 0) begin
          // Any partial message is simply dropped.
          slot_busy[s]   = 1'b0;
          part_held[s]   = 1'b0;
          have_bytes[s]  = '0;
          refuse_rest[s] = 1'b0;
          note_result(aclfrt_pkg::EV_CLOSED, s, '0);
        end else begin
          note_result(aclfrt_pkg::EV_CLOSE_UNK, 0, '0);
        end
      end
      aclfrt_pkg::CMD_DATA: begin
        s = find_conn(handle);
        if (s < 0) begin
          note_result(aclfrt_pkg::EV_UNKNOWN, 0, '0);
        end else begin
          go_on = 1'b1;
          if (boundary != aclfrt_pkg::PB_CONTINUATION) begin
            // A start packet pushes out whatever was gathered so far.
            if (part_held[s]) begin
              note_result(aclfrt_pkg::EV_FLUSH, s, have_bytes[s]);
              part_held[s]  = 1'b0;
              have_bytes[s] = '0;
            end
            refuse_rest[s] = refused;
            if (refused) begin
              note_result(aclfrt_pkg::EV_REFUSED, s, '0);
              go_on = 1'b0;
            end else begin
              want_bytes[s] = declared;
            end
          end else if (refuse_rest[s]) begin
            note_result(aclfrt_pkg::EV_SKIPPED, s, '0);
            go_on = 1'b0;
          end
          if (go_on) begin
            // Remainder and running total both wrap at 16 bits.
            remain = want_bytes[s] - have_bytes[s];
            total  = have_bytes[s] + plen;
            if (plen >= remain) begin
              note_result(aclfrt_pkg::EV_DELIVERED, s, total);
              part_held[s]  = 1'b0;
              have_bytes[s] = '0;
            end else begin
              have_bytes[s] = total;
              part_held[s]  = 1'b1;
              note_result(aclfrt_pkg::EV_QUEUED, s, '0);
            end
          end
        end
      end
      default: ;
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endfunction

  function automatic void check_field(string name, logic [15:0] expected,
                                      logic [15:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      fail_tally++;
    end
  endfunction

  // Sample both channels at the rising edge; results are checked before the
  // command of the same edge is predicted, which cannot have caused them.
  always @(posedge clk) begin : watch
    aclfrt_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < aclfrt_pkg::SLOTS; i++) begin
        slot_busy[i]   = 1'b0;
        slot_conn[i]   = '0;
        want_bytes[i]  = '0;
        have_bytes[i]  = '0;
        part_held[i]   = 1'b0;
        refuse_rest[i] = 1'b0;
      end
      foreach (event_tally[i]) event_tally[i] = 0;
      awaited_results.delete();
      fail_tally    = 0;
      checked_tally = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("Unexpected result transfer: event_code %0d slot_index %0d message_bytes %0d",
                 res_ch.event_code, res_ch.slot_index, res_ch.message_bytes);
          fail_tally++;
        end else begin
          want = awaited_results.pop_front();
          checked_tally++;
          event_tally[int'(want.ev)]++;
          check_field("event_code", 16'(want.ev), 16'(res_ch.event_code));
          check_field("slot_index", 16'(want.slot), 16'(res_ch.slot_index));
          check_field("message_bytes", want.bytes, res_ch.message_bytes);
          check_field("last_result", 16'(want.last), 16'(res_ch.last_result));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_command(aclfrt_pkg::cmd_t'(cmd_ch.command), cmd_ch.link_id,
                        cmd_ch.boundary_flag, cmd_ch.frag_len, cmd_ch.declared_size,
                        cmd_ch.check_refused);
      end
    end
    mismatch_count <= fail_tally;
    awaited_count  <= awaited_results.size();
    checked_count  <= checked_tally;
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// ACL reassembly tracker: testbench top
// Drives open, close and data packet commands into the tracker, first a
// directed run through the table's corner cases and then random traffic made
// mostly of whole messages split into fragments. Both channels pause at
// random. The checker beside the block judges every result; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 2000;
  // Several times the back end's slowest turn on one command.
  localparam int DRAIN_CYCLES = 4 * aclfrt_pkg::SLOTS + 12;

  logic clk;
  logic rst_n;
  logic in_steady  = 1'b0;
  logic out_steady = 1'b0;

  int mismatches;
  int awaited;
  int checked;
  int commands_sent = 0;
  int ignored_sent  = 0;
  int idle_cycles   = 0;

  logic [11:0] conn_pool [5];

  aclfrt_in_if  cmd_ch ();
  aclfrt_out_if res_ch ();

  acl_fragment_reassembly_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  acl_reassembly_checker i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_ch         (cmd_ch),
    .res_ch         (res_ch),
    .mismatch_count (mismatches),
    .awaited_count  (awaited),
    .checked_count  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result receiver: a random stall before each transfer, none in steady stretches.
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = out_steady ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        res_ch.ready <= 1'b0;
        @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("No transfer on either channel for %0d cycles", IDLE_LIMIT);
      $display("acl_fragment_reassembly_tracker test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One command transfer, after a random gap unless in a steady stretch.
  task automatic send_cmd(aclfrt_pkg::cmd_t cmd, logic [11:0] handle, logic [1:0] boundary,
                          logic [15:0] plen, logic [15:0] declared, logic refused);
    int gap;
    @(negedge clk);
    gap = in_steady ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.command       <= cmd;
    cmd_ch.link_id       <= handle;
    cmd_ch.boundary_flag <= boundary;
    cmd_ch.frag_len      <= plen;
    cmd_ch.declared_size <= declared;
    cmd_ch.check_refused <= refused;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    if (cmd == aclfrt_pkg::CMD_NONE) ignored_sent++;
    else commands_sent++;
  endtask

  // Mostly short lengths, some full-range values and the two extremes.
  function automatic logic [15:0] pick_bytes(int unsigned cap);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    if (roll < 5) return 16'($urandom);
    return 16'($urandom_range(0, cap));
  endfunction

  // Handles mostly come from a small pool so that lookups tend to hit.
  function automatic logic [11:0] pick_conn();
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    return conn_pool[$urandom_range(0, 4)];
  endfunction

  // A start packet followed by continuations that usually cover the declared size.
  task automatic send_message();
    logic [11:0] conn;
    logic [15:0] size;
    logic [1:0]  start_flag;
    int unsigned chunk;
    int unsigned left;
    int          pieces;
    conn       = pick_conn();
    size       = 16'($urandom_range(1, 400));
    start_flag = 2'($urandom_range(0, 2));
    if (start_flag == aclfrt_pkg::PB_CONTINUATION) start_flag = 2'd3;
    chunk = $urandom_range(0, size);
    send_cmd(aclfrt_pkg::CMD_DATA, conn, start_flag, 16'(chunk), size,
             $urandom_range(0, 11) == 0);
    left   = size - chunk;
    pieces = 0;
    while (left > 0 && pieces < 8) begin
      // Now and then stop short, so that the next start flushes the remnant.
      if ($urandom_range(0, 15) == 0) break;
      chunk = $urandom_range(1, left);
      if ($urandom_range(0, 9) == 0) chunk = left + $urandom_range(1, 50);
      send_cmd(aclfrt_pkg::CMD_DATA, conn, aclfrt_pkg::PB_CONTINUATION, 16'(chunk),
               16'($urandom), 1'($urandom));
      left = (chunk >= left) ? 0 : left - chunk;
      pieces++;
    end
  endtask

  // A single command of any kind with loosely chosen fields.
  task automatic send_noise();
    aclfrt_pkg::cmd_t cmd;
    case ($urandom_range(0, 19))
      0, 1, 2: cmd = aclfrt_pkg::CMD_OPEN;
      3, 4:    cmd = aclfrt_pkg::CMD_CLOSE;
      5:       cmd = aclfrt_pkg::CMD_NONE;
      default: cmd = aclfrt_pkg::CMD_DATA;
    endcase
    send_cmd(cmd, pick_conn(), 2'($urandom), pick_bytes(300), pick_bytes(400),
             $urandom_range(0, 7) == 0);
  endtask

  initial begin : stimulus
    rst_n                = 1'b0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.command       = aclfrt_pkg::CMD_DATA;
    cmd_ch.link_id       = '0;
    cmd_ch.boundary_flag = '0;
    cmd_ch.frag_len      = '0;
    cmd_ch.declared_size = '0;
    cmd_ch.check_refused = 1'b0;
    conn_pool = '{12'h000, 12'hFFF, 12'h5A5, 12'h123, 12'($urandom)};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, filling it, duplicates and message corner cases.
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h000, 2'd0, 16'd5, 16'd5, 1'b0);
    send_cmd(aclfrt_pkg::CMD_CLOSE, 12'hFFF, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_OPEN,  12'h000, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_OPEN,  12'hFFF, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_OPEN,  12'h000, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_OPEN,  12'h5A5, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_OPEN,  12'h123, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_NONE,  12'h123, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h000, aclfrt_pkg::PB_CONTINUATION, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h000, 2'd0, 16'd40, 16'd100, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h000, aclfrt_pkg::PB_CONTINUATION, 16'd30, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h000, 2'd2, 16'hFFFF, 16'hFFFF, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'hFFF, 2'd3, 16'd20, 16'd50, 1'b1);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'hFFF, aclfrt_pkg::PB_CONTINUATION, 16'd10, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'hFFF, 2'd0, 16'd4, 16'd10, 1'b0);
    send_cmd(aclfrt_pkg::CMD_CLOSE, 12'hFFF, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'hFFF, 2'd0, 16'd1, 16'd1, 1'b0);
    send_cmd(aclfrt_pkg::CMD_OPEN,  12'h0AB, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h0AB, aclfrt_pkg::PB_CONTINUATION, 16'd7, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_CLOSE, 12'h000, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h000, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h5A5, 2'd0, 16'h8000, 16'hFFFF, 1'b0);
    send_cmd(aclfrt_pkg::CMD_DATA,  12'h5A5, aclfrt_pkg::PB_CONTINUATION, 16'hFFFF, 16'd0,
             1'b0);
    send_cmd(aclfrt_pkg::CMD_CLOSE, 12'h5A5, 2'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(aclfrt_pkg::CMD_CLOSE, 12'h0AB, 2'd0, 16'd0, 16'd0, 1'b0);

    // Random: mostly fragmented messages, with table churn and stray commands.
    while (commands_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        in_steady  = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_message();
        5: send_cmd(aclfrt_pkg::CMD_OPEN, pick_conn(), 2'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom));
        6: send_cmd(aclfrt_pkg::CMD_CLOSE, pick_conn(), 2'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom));
        default: send_noise();
      endcase
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b0;

    // Let the awaited results drain, then allow for late or stray ones.
    do @(posedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Summary: %0d commands and %0d unused codes sent, %0d results checked.",
             commands_sent, ignored_sent, checked);
    $write("Events: queued %0d delivered %0d flushed %0d unknown %0d refused %0d",
           i_check.event_tally[aclfrt_pkg::EV_QUEUED],
           i_check.event_tally[aclfrt_pkg::EV_DELIVERED],
           i_check.event_tally[aclfrt_pkg::EV_FLUSH],
           i_check.event_tally[aclfrt_pkg::EV_UNKNOWN],
           i_check.event_tally[aclfrt_pkg::EV_REFUSED]);
    $display(" skipped %0d opened %0d full %0d closed %0d close-unknown %0d",
             i_check.event_tally[aclfrt_pkg::EV_SKIPPED],
             i_check.event_tally[aclfrt_pkg::EV_OPENED],
             i_check.event_tally[aclfrt_pkg::EV_FULL],
             i_check.event_tally[aclfrt_pkg::EV_CLOSED],
             i_check.event_tally[aclfrt_pkg::EV_CLOSE_UNK]);
    if (mismatches == 0 && awaited == 0) begin
      $display("acl_fragment_reassembly_tracker test passed");
    end else begin
      $display("acl_fragment_reassembly_tracker test failed");
    end
    $finish;
  end

endmodule
